### src/mie_pkg.sv
// Shared types and constants for the modular inverse block.
package mie_pkg;

   // Default operand width and reset value of the modulus register
   localparam int unsigned VALUE_BITS = 30;
   localparam logic [63:0] MODULUS_RESET = 64'd1000000007;

   // Sequencer states of the Euclid core
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_DIVIDE,
      ST_REDUCE,
      ST_DONE
   } core_state_type;

endpackage

### src/mie_divider.sv
// Radix-2 restoring divider that also accumulates quotient times a signed multiplicand.
module mie_divider #(
   parameter int unsigned VALUE_BITS = mie_pkg::VALUE_BITS
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [VALUE_BITS-1:0]        dividend,
   input  logic [VALUE_BITS-1:0]        divisor,
   input  logic signed [VALUE_BITS+1:0] mult,
   output logic                         done,
   output logic [VALUE_BITS-1:0]        remainder,
   output logic signed [VALUE_BITS+1:0] product
);

   localparam int unsigned XW = VALUE_BITS + 2;
   localparam int unsigned CW = $clog2(VALUE_BITS);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [CW-1:0]         cnt_ff, cnt_in;
   logic [VALUE_BITS-1:0] quo_ff, quo_in;
   logic [VALUE_BITS-1:0] rem_ff, rem_in;
   logic [VALUE_BITS-1:0] dvs_ff, dvs_in;
   logic signed [XW-1:0]  mul_ff, mul_in;
   logic signed [XW-1:0]  prod_ff, prod_in;
   logic [VALUE_BITS:0]   shifted;
   logic [VALUE_BITS:0]   diff;
   logic                  qbit;

   // One quotient bit per cycle, MSB first; fold it into the running product
   always_comb begin
      shifted = {rem_ff, quo_ff[VALUE_BITS-1]};
      diff    = shifted - {1'b0, dvs_ff};
      qbit    = ~diff[VALUE_BITS];
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      mul_in  = mul_ff;
      prod_in = prod_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CW'(VALUE_BITS - 1);
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
         mul_in  = mult;
         prod_in = '0;
      end else if (busy_ff) begin
         quo_in  = {quo_ff[VALUE_BITS-2:0], 1'b0};
         rem_in  = qbit ? diff[VALUE_BITS-1:0] : shifted[VALUE_BITS-1:0];
         prod_in = (prod_ff <<< 1) + (qbit ? mul_ff : XW'(0));
         cnt_in  = cnt_ff - CW'(1);
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Hold control state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // Advance datapath registers
   always_ff @(posedge clock) begin
      cnt_ff  <= cnt_in;
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      dvs_ff  <= dvs_in;
      mul_ff  <= mul_in;
      prod_ff <= prod_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;
   assign product   = prod_ff;

endmodule

### src/mie_core.sv
// Extended Euclid sequencer: remainder/coefficient registers, final reduction.
module mie_core #(
   parameter int unsigned VALUE_BITS = mie_pkg::VALUE_BITS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [VALUE_BITS-1:0] value,
   input  logic [VALUE_BITS-1:0] modulus,
   output logic                  idle,
   output logic                  res_valid,
   input  logic                  res_ready,
   output logic [VALUE_BITS-1:0] inverse,
   output logic                  coprime
);

   localparam int unsigned XW = VALUE_BITS + 2;

   mie_pkg::core_state_type state_ff, state_in;
   logic [VALUE_BITS-1:0]   r1_ff, r1_in;
   logic [VALUE_BITS-1:0]   r2_ff, r2_in;
   logic signed [XW-1:0]    x1_ff, x1_in;
   logic signed [XW-1:0]    x2_ff, x2_in;
   logic [VALUE_BITS-1:0]   inv_ff, inv_in;
   logic                    cop_ff, cop_in;
   logic                    div_start;
   logic                    div_done;
   logic [VALUE_BITS-1:0]   div_rem;
   logic signed [XW-1:0]    div_prod;
   logic signed [XW-1:0]    m_ext;
   logic signed [XW-1:0]    red;

   mie_divider #(
      .VALUE_BITS(VALUE_BITS)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (r1_ff),
      .divisor  (r2_ff),
      .mult     (x2_ff),
      .done     (div_done),
      .remainder(div_rem),
      .product  (div_prod)
   );

   assign m_ext = $signed({2'b00, modulus});

   // Bring the coefficient from [-m, m] into [0, m-1]
   always_comb begin
      if (x1_ff < 0) begin
         red = x1_ff + m_ext;
      end else if (x1_ff >= m_ext) begin
         red = x1_ff - m_ext;
      end else begin
         red = x1_ff;
      end
   end

   // Next state and datapath updates
   always_comb begin
      state_in  = state_ff;
      r1_in     = r1_ff;
      r2_in     = r2_ff;
      x1_in     = x1_ff;
      x2_in     = x2_ff;
      inv_in    = inv_ff;
      cop_in    = cop_ff;
      div_start = 1'b0;
      unique case (state_ff)
         mie_pkg::ST_IDLE: begin
            if (start) begin
               r1_in = value;
               r2_in = modulus;
               x1_in = XW'(1);
               x2_in = '0;
               if (modulus == '0) begin
                  inv_in   = '0;
                  cop_in   = 1'b0;
                  state_in = mie_pkg::ST_DONE;
               end else begin
                  state_in = mie_pkg::ST_CHECK;
               end
            end
         end
         mie_pkg::ST_CHECK: begin
            if (r2_ff == '0) begin
               state_in = mie_pkg::ST_REDUCE;
            end else begin
               div_start = 1'b1;
               state_in  = mie_pkg::ST_DIVIDE;
            end
         end
         mie_pkg::ST_DIVIDE: begin
            if (div_done) begin
               x1_in    = x2_ff;
               x2_in    = x1_ff - div_prod;
               r1_in    = r2_ff;
               r2_in    = div_rem;
               state_in = mie_pkg::ST_CHECK;
            end
         end
         mie_pkg::ST_REDUCE: begin
            inv_in   = red[VALUE_BITS-1:0];
            cop_in   = (r1_ff == VALUE_BITS'(1));
            state_in = mie_pkg::ST_DONE;
         end
         mie_pkg::ST_DONE: begin
            if (res_ready) begin
               state_in = mie_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = mie_pkg::ST_IDLE;
         end
      endcase
   end

   // Hold sequencer state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mie_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Advance working registers
   always_ff @(posedge clock) begin
      r1_ff  <= r1_in;
      r2_ff  <= r2_in;
      x1_ff  <= x1_in;
      x2_ff  <= x2_in;
      inv_ff <= inv_in;
      cop_ff <= cop_in;
   end

   assign idle      = (state_ff == mie_pkg::ST_IDLE);
   assign res_valid = (state_ff == mie_pkg::ST_DONE);
   assign inverse   = inv_ff;
   assign coprime   = cop_ff;

`ifndef SYNTHESIS
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      start |-> (state_ff == mie_pkg::ST_IDLE))
      else $error("start outside idle");

   a_done_in_divide: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == mie_pkg::ST_DIVIDE))
      else $error("divider done outside divide state");

   a_coef_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == mie_pkg::ST_REDUCE) |-> ((x1_ff >= -m_ext) && (x1_ff <= m_ext)))
      else $error("coefficient out of range at reduction");

   a_inv_range: assert property (@(posedge clock) disable iff (reset)
      res_valid |-> ((inv_ff < modulus) || (inv_ff == '0)))
      else $error("inverse not below modulus");

   a_reduce_to_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == mie_pkg::ST_REDUCE) |=> (state_ff == mie_pkg::ST_DONE))
      else $error("reduction did not finish");
`endif

endmodule

### src/modular_inverse_ext_euclid_top.sv
// Top level of the modular inverse block: stream ports, modulus register, result register.
//
// Computes value^-1 mod modulus with the extended Euclidean algorithm and flags
// whether gcd(value, modulus) is one. One item is in work at a time: req_tready is
// high only while the core is idle. Each Euclid step runs the shared radix-2
// divider and then updates the remainder and coefficient registers; a final
// reduction brings the coefficient into [0, modulus-1] before hand-off. A zero
// modulus returns zero with coprime low without running the divider. A finished
// result sits in an output register, so the next item is accepted while it waits
// for rsp_tready. Write csr_wr_data with csr_wr_en only while no item is in work.
module modular_inverse_ext_euclid_top #(
   parameter int unsigned VALUE_BITS = mie_pkg::VALUE_BITS
) (
   input  logic                                clock,
   input  logic                                reset,
   // request stream
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [((VALUE_BITS+7)/8)*8-1:0]     req_tdata,   // [VALUE_BITS-1:0] value
   // response stream
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [((VALUE_BITS+7)/8)*8-1:0]     rsp_tdata,   // [VALUE_BITS-1:0] inverse
   output logic                                rsp_tuser,   // [0] coprime
   // modulus register
   input  logic                                csr_wr_en,
   input  logic [VALUE_BITS-1:0]               csr_wr_data
);

   localparam int unsigned DW = ((VALUE_BITS + 7) / 8) * 8;

   logic [VALUE_BITS-1:0] modulus_ff, modulus_in;
   logic                  out_valid_ff, out_valid_in;
   logic [VALUE_BITS-1:0] out_inv_ff, out_inv_in;
   logic                  out_cop_ff, out_cop_in;
   logic                  core_idle;
   logic                  core_valid;
   logic                  core_ready;
   logic [VALUE_BITS-1:0] core_inv;
   logic                  core_cop;
   logic                  req_xfer;

   assign req_tready = core_idle;
   assign req_xfer   = req_tvalid & core_idle;

   mie_core #(
      .VALUE_BITS(VALUE_BITS)
   ) u_core (
      .clock    (clock),
      .reset    (reset),
      .start    (req_xfer),
      .value    (req_tdata[VALUE_BITS-1:0]),
      .modulus  (modulus_ff),
      .idle     (core_idle),
      .res_valid(core_valid),
      .res_ready(core_ready),
      .inverse  (core_inv),
      .coprime  (core_cop)
   );

   // Load the output register when it is empty or its transfer completes
   assign core_ready = ~out_valid_ff | rsp_tready;

   always_comb begin
      modulus_in   = csr_wr_en ? csr_wr_data : modulus_ff;
      out_valid_in = out_valid_ff;
      out_inv_in   = out_inv_ff;
      out_cop_in   = out_cop_ff;
      if (core_ready) begin
         out_valid_in = core_valid;
         if (core_valid) begin
            out_inv_in = core_inv;
            out_cop_in = core_cop;
         end
      end
   end

   // Hold control state and the modulus register
   always_ff @(posedge clock) begin
      if (reset) begin
         modulus_ff   <= VALUE_BITS'(mie_pkg::MODULUS_RESET);
         out_valid_ff <= 1'b0;
      end else begin
         modulus_ff   <= modulus_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Hold result payload
   always_ff @(posedge clock) begin
      out_inv_ff <= out_inv_in;
      out_cop_ff <= out_cop_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = DW'(out_inv_ff);
   assign rsp_tuser  = out_cop_ff;

endmodule

### tb/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the modular inverse block.

module tb;

   localparam int unsigned VB          = mie_pkg::VALUE_BITS;
   localparam int unsigned DW          = ((VB + 7) / 8) * 8;
   localparam logic [VB-1:0] VALUE_MAX = {VB{1'b1}};
   localparam logic [VB-1:0] PRIME_1E9 = mie_pkg::MODULUS_RESET[VB-1:0];
   localparam int unsigned CYCLE_LIMIT = 4000000;
   localparam int unsigned HOLD_AFTER  = 40;     // results seen before the long hold-off
   localparam int unsigned HOLD_CYCLES = 3000;
   localparam int unsigned DRAIN_PAD   = 8;

   typedef struct packed {
      logic [VB-1:0] inverse;
      logic          coprime;
   } inv_result_type;

   // Tracks the modulus, predicts each inverse and checks results in order
   class inverse_scoreboard;
      logic [VB-1:0]  modulus;
      inv_result_type expected_q[$];
      int unsigned    n_fail;
      int unsigned    results_seen;

      function new();
         modulus      = PRIME_1E9;
         n_fail       = 0;
         results_seen = 0;
      endfunction

      // Extended Euclid on (a, m), tracking the coefficient of a
      function inv_result_type solve_inverse(logic [VB-1:0] a, logic [VB-1:0] m);
         longint unsigned r_prev, r_cur, quot, rem;
         longint          x_prev, x_cur, x_next, red;
         inv_result_type  res;
         res.inverse = '0;
         res.coprime = 1'b0;
         if (m == 0)
            return res;
         r_prev = a;
         r_cur  = m;
         x_prev = 1;
         x_cur  = 0;
         while (r_cur != 0) begin
            quot   = r_prev / r_cur;
            rem    = r_prev % r_cur;
            x_next = x_prev - longint'(quot) * x_cur;
            x_prev = x_cur;
            x_cur  = x_next;
            r_prev = r_cur;
            r_cur  = rem;
         end
         // Bring the coefficient into 0 .. m-1
         red = x_prev % longint'(m);
         if (red < 0)
            red += longint'(m);
         res.inverse = red[VB-1:0];
         res.coprime = (r_prev == 1);
         return res;
      endfunction

      function void note_value(logic [VB-1:0] value);
         expected_q.push_back(solve_inverse(value, modulus));
      endfunction

      function int unsigned pending();
         return expected_q.size();
      endfunction

      function void check_result(logic [VB-1:0] got_inv, logic got_cop);
         inv_result_type exp_r;
         results_seen++;
         if (expected_q.size() == 0) begin
            $error("unexpected result: inverse %0d, coprime %0b", got_inv, got_cop);
            n_fail++;
            return;
         end
         exp_r = expected_q.pop_front();
         if (got_inv !== exp_r.inverse) begin
            $error("inverse: expected %0d, got %0d", exp_r.inverse, got_inv);
            n_fail++;
         end
         if (got_cop !== exp_r.coprime) begin
            $error("coprime: expected %0b, got %0b", exp_r.coprime, got_cop);
            n_fail++;
         end
      endfunction
   endclass

   logic          clock       = 1'b0;
   logic          reset       = 1'b1;
   logic          req_tvalid  = 1'b0;
   logic          req_tready;
   logic [DW-1:0] req_tdata   = '0;   // [VB-1:0] value
   logic          rsp_tvalid;
   logic          rsp_tready  = 1'b0;
   logic [DW-1:0] rsp_tdata;          // [VB-1:0] inverse
   logic          rsp_tuser;          // [0] coprime
   logic          csr_wr_en   = 1'b0;
   logic [VB-1:0] csr_wr_data = '0;

   inverse_scoreboard inv_sb;

   modular_inverse_ext_euclid_top #(.VALUE_BITS(VB)) u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // Clock and reset
   initial begin
      forever #6 clock = ~clock;
   end

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
   end

   // Idle length: mostly short, a few long
   function automatic int unsigned idle_length();
      int unsigned r;
      r = $urandom_range(0, 19);
      if (r < 15)
         return $urandom_range(1, 3);
      else if (r < 19)
         return $urandom_range(4, 12);
      return $urandom_range(25, 80);
   endfunction

   // Random operand with a bias toward the interesting corners
   function automatic logic [VB-1:0] random_value(logic [VB-1:0] m);
      logic [VB-1:0] v;
      case ($urandom_range(0, 9))
         0:       v = VB'($urandom_range(0, 15));
         1:       v = m - VB'($urandom_range(0, 3));
         2:       v = m + VB'($urandom_range(1, 3));
         3:       v = m * VB'($urandom_range(2, 3));
         4:       v = VB'(21 * $urandom_range(1, 1000000));
         default: v = VB'($urandom());
      endcase
      return v;
   endfunction

   // Offer one value and hold it until the block takes the transfer
   task automatic send_value(input logic [VB-1:0] value);
      int unsigned gap;
      gap = ($urandom_range(0, 9) < 6) ? 0 : idle_length();
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= DW'(value);
      do @(posedge clock); while (!req_tready);
      inv_sb.note_value(value);
   endtask

   // Drop the request and wait for every outstanding result
   task automatic drain();
      req_tvalid <= 1'b0;
      while (inv_sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_PAD) @(posedge clock);
   endtask

   // Write the modulus once the block is idle
   task automatic write_modulus(input logic [VB-1:0] m);
      drain();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= m;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      inv_sb.modulus = m;
   endtask

   task automatic run_random(input int unsigned count, input logic [VB-1:0] m);
      write_modulus(m);
      repeat (count) send_value(random_value(m));
   endtask

   // Result side: check each transfer, stall at random, hold off once for a long stretch
   initial begin
      int unsigned stall, window;
      bit          calm, held_off;
      stall    = 0;
      window   = 0;
      calm     = 1'b0;
      held_off = 1'b0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (rsp_tvalid && rsp_tready)
            inv_sb.check_result(rsp_tdata[VB-1:0], rsp_tuser);
         // Alternate between stretches with and without stalls
         if (window == 0) begin
            window = $urandom_range(100, 400);
            calm   = ($urandom_range(0, 2) == 0);
         end else begin
            window--;
         end
         if (!held_off && inv_sb.results_seen == HOLD_AFTER) begin
            held_off = 1'b1;
            stall    = HOLD_CYCLES;
         end else if (stall == 0 && !calm && $urandom_range(0, 7) == 0) begin
            stall = idle_length();
         end
         if (stall != 0) begin
            rsp_tready <= 1'b0;
            stall--;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Run limit
   initial begin
      int unsigned cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("Test completed with failures");
      $finish;
   end

   // Stimulus
   initial begin
      logic [VB-1:0] m;
      inv_sb = new();
      @(negedge reset);
      @(posedge clock);

      // Reset modulus: zero, unit, edges around the modulus, full range, bit patterns
      send_value('0);
      send_value(VB'(1));
      send_value(VB'(2));
      send_value(PRIME_1E9 - 1'b1);
      send_value(PRIME_1E9);
      send_value(PRIME_1E9 + 1'b1);
      send_value(VALUE_MAX);
      send_value(VB'(30'h2AAA_AAAA));
      send_value(VB'(30'h1555_5555));

      // Largest modulus, composite: shared factors and value equal to the modulus
      write_modulus(VALUE_MAX);
      send_value('0);
      send_value(VB'(1));
      send_value(VB'(3));
      send_value(VB'(77));
      send_value(VALUE_MAX);
      send_value(VALUE_MAX - 1'b1);

      // Smallest modulus in range
      write_modulus(VB'(2));
      send_value('0);
      send_value(VB'(1));
      send_value(VB'(2));
      send_value(VALUE_MAX);

      // Modulus one
      write_modulus(VB'(1));
      send_value('0);
      send_value(VB'(12345));

      // Modulus zero
      write_modulus('0);
      send_value('0);
      send_value(VB'(1));
      send_value(VALUE_MAX);

      // Random phases over several moduli
      run_random(115, PRIME_1E9);
      run_random(60, VB'(65537));
      run_random(80, VALUE_MAX);
      run_random(20, VB'(2));
      repeat (2) begin
         m = VB'($urandom_range(2, VALUE_MAX));
         run_random(35, m);
      end
      repeat (2) begin
         m = VB'($urandom_range(2, 1000));
         run_random(25, m);
      end

      drain();
      repeat (40) @(posedge clock);
      if (inv_sb.n_fail == 0 && inv_sb.pending() == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
